// ----- sv/rtd_pkg.sv -----
package rtd_pkg;

    localparam int OFS_W = 6;
    localparam int CNT_W = 7;
    localparam int BYTE_W = 8;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [BYTE_W-1:0] CODE_RUN = 8'h31;
    localparam logic [BYTE_W-1:0] CODE_END = 8'h0A;
    localparam logic [BYTE_W-1:0] DIGIT_0 = 8'h30;
    localparam logic [BYTE_W-1:0] DIGIT_9 = 8'h39;

    localparam logic [OFS_W-1:0] RUN_OFFSET_RST = 6'd3;
    localparam logic [OFS_W-1:0] LIT_OFFSET_RST = 6'd1;

    // Register index taken from paddr[2].
    localparam logic REG_RUN_OFFSET = 1'b0;
    localparam logic REG_LIT_OFFSET = 1'b1;

    // One unit of work for the back end: emit data count times, with the
    // end-of-member flag on every copy.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  count;
        logic              eom;
    } t_cmd;

    function automatic logic [3:0] count_digit(input logic [BYTE_W-1:0] b);
        logic [3:0] d;
        d = 4'd0;
        if (b inside {[DIGIT_0:DIGIT_9]}) begin
            d = b[3:0];
        end
        return d;
    endfunction

endpackage

// ----- sv/rtd_front.sv -----
module rtd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [rtd_pkg::BYTE_W-1:0]    i_byte,
    input  logic [rtd_pkg::OFS_W-1:0]     i_run_offset,
    input  logic [rtd_pkg::OFS_W-1:0]     i_lit_offset,
    output logic                          o_push,
    output rtd_pkg::t_cmd                 o_cmd
);

    typedef enum logic [4:0] {
        PH_CODE      = 5'b00001,
        PH_RUN_COUNT = 5'b00010,
        PH_RUN_SYM   = 5'b00100,
        PH_LIT_COUNT = 5'b01000,
        PH_LIT_DATA  = 5'b10000
    } t_phase;

    t_phase                     r_phase, n_phase;
    logic [rtd_pkg::CNT_W-1:0]  r_rem, n_rem;
    logic [rtd_pkg::CNT_W-1:0]  w_digit;
    logic [rtd_pkg::CNT_W-1:0]  w_run_len;
    logic [rtd_pkg::CNT_W-1:0]  w_lit_len;

    assign w_digit   = {3'b000, rtd_pkg::count_digit(i_byte)};
    assign w_run_len = w_digit + {1'b0, i_run_offset};
    assign w_lit_len = w_digit + {1'b0, i_lit_offset};

    always_comb begin
        n_phase = r_phase;
        n_rem   = r_rem;
        o_push  = 1'b0;
        o_cmd   = '{data: i_byte, count: rtd_pkg::CNT_W'(1), eom: 1'b0};
        if (i_accept) begin
            case (r_phase)
                PH_RUN_COUNT: begin
                    n_rem   = w_run_len;
                    n_phase = PH_RUN_SYM;
                end
                PH_RUN_SYM: begin
                    o_push    = (r_rem != '0);
                    o_cmd.count = r_rem;
                    n_rem     = '0;
                    n_phase   = PH_CODE;
                end
                PH_LIT_COUNT: begin
                    n_rem   = w_lit_len;
                    n_phase = (w_lit_len == '0) ? PH_CODE : PH_LIT_DATA;
                end
                PH_LIT_DATA: begin
                    o_push = 1'b1;
                    n_rem  = r_rem - rtd_pkg::CNT_W'(1);
                    if (r_rem == rtd_pkg::CNT_W'(1)) begin
                        n_phase = PH_CODE;
                    end
                end
                default: begin
                    n_rem = '0;
                    if (i_byte == rtd_pkg::CODE_END) begin
                        o_push     = 1'b1;
                        o_cmd.data = '0;
                        o_cmd.eom  = 1'b1;
                        n_phase    = PH_CODE;
                    end else if (i_byte == rtd_pkg::CODE_RUN) begin
                        n_phase = PH_RUN_COUNT;
                    end else begin
                        n_phase = PH_LIT_COUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CODE;
            r_rem   <= '0;
        end else begin
            r_phase <= n_phase;
            r_rem   <= n_rem;
        end
    end

endmodule

// ----- sv/rtd_queue.sv -----
module rtd_queue #(
    parameter int DEPTH = rtd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rtd_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output rtd_pkg::t_cmd  o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rtd_pkg::t_cmd     r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_wr, w_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return q;
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (w_rd) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ----- sv/rtd_back.sv -----
module rtd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  rtd_pkg::t_cmd               i_cmd,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [rtd_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                        o_last_of_run,
    output logic                        o_end_of_member
);

    logic                        r_valid;
    logic [rtd_pkg::BYTE_W-1:0]  r_byte;
    logic                        r_last;
    logic                        r_eom;
    logic [rtd_pkg::BYTE_W-1:0]  r_data;
    logic [rtd_pkg::CNT_W-1:0]   r_left;
    logic                        w_free;

    // The output slot can take a new result when empty or being drained.
    assign w_free = !r_valid || i_out_ready;
    assign o_pop  = w_free && (r_left == '0) && !i_empty;

    assign o_out_valid     = r_valid;
    assign o_out_byte      = r_byte;
    assign o_last_of_run   = r_last;
    assign o_end_of_member = r_eom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
        end else if (w_free) begin
            if (r_left != '0) begin
                r_valid <= 1'b1;
                r_left  <= r_left - rtd_pkg::CNT_W'(1);
            end else if (!i_empty) begin
                r_valid <= 1'b1;
                r_left  <= i_cmd.count - rtd_pkg::CNT_W'(1);
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free) begin
            if (r_left != '0) begin
                r_byte <= r_data;
                r_last <= (r_left == rtd_pkg::CNT_W'(1));
            end else if (!i_empty) begin
                r_byte <= i_cmd.data;
                r_data <= i_cmd.data;
                r_last <= (i_cmd.count == rtd_pkg::CNT_W'(1));
                r_eom  <= i_cmd.eom;
            end
        end
    end

endmodule

// ----- sv/rle_token_decoder.sv -----
// A result reaches the output through the command queue and then the output register.
// Throughput: one archive byte per cycle while the command queue has room, and one result
// per cycle while the receiver is ready; a run keeps the back end busy until all copies go.
// Reset (synchronous, active low) returns the parser to the code position, empties the
// queue and the output slot, and sets run_offset to 3 and literal_offset to 1.
module rle_token_decoder #(
    parameter int QUEUE_DEPTH = rtd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Archive byte stream.
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [rtd_pkg::BYTE_W-1:0]    i_archive_byte,
    // Decoded results.
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [rtd_pkg::BYTE_W-1:0]    o_out_byte,
    output logic                          o_last_of_run,
    output logic                          o_end_of_member,
    // Register port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rtd_pkg::PADDR_W-1:0]   paddr,
    input  logic [rtd_pkg::PDATA_W-1:0]   pwdata,
    output logic [rtd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [rtd_pkg::OFS_W-1:0]  r_run_offset;
    logic [rtd_pkg::OFS_W-1:0]  r_lit_offset;
    logic                       w_in_accept;
    logic                       w_push;
    logic                       w_pop;
    logic                       w_full;
    logic                       w_empty;
    rtd_pkg::t_cmd              w_push_cmd;
    rtd_pkg::t_cmd              w_head_cmd;

    // The register port never inserts wait states. Registers sit at byte
    // addresses 0 and 4, so bit 2 of the address selects between them.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_offset <= rtd_pkg::RUN_OFFSET_RST;
            r_lit_offset <= rtd_pkg::LIT_OFFSET_RST;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == rtd_pkg::REG_RUN_OFFSET) begin
                r_run_offset <= pwdata[rtd_pkg::OFS_W-1:0];
            end else begin
                r_lit_offset <= pwdata[rtd_pkg::OFS_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == rtd_pkg::REG_LIT_OFFSET) begin
            prdata[rtd_pkg::OFS_W-1:0] = r_lit_offset;
        end else begin
            prdata[rtd_pkg::OFS_W-1:0] = r_run_offset;
        end
    end

    // The front end takes a byte whenever the queue has a free entry. Each
    // transfer pushes at most one command, so this alone keeps the queue
    // from overflowing; bytes that push nothing are also held while it is full.
    assign o_in_ready  = !w_full;
    assign w_in_accept = i_in_valid && o_in_ready;

    // Front end: walks the token grammar (code, count, symbol or literal
    // data) and turns each data-producing byte and each end code into a command.
    rtd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_in_accept),
        .i_byte       (i_archive_byte),
        .i_run_offset (r_run_offset),
        .i_lit_offset (r_lit_offset),
        .o_push       (w_push),
        .o_cmd        (w_push_cmd)
    );

    // Short command queue that decouples parsing from run expansion.
    rtd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_cmd   (w_head_cmd)
    );

    // Back end: expands each command into its copies, one per cycle while the
    // receiver is ready, and holds each result in the output register until its transfer.
    rtd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (w_empty),
        .i_cmd           (w_head_cmd),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_last_of_run   (o_last_of_run),
        .o_end_of_member (o_end_of_member)
    );

endmodule
